// ===== rtl/priority_ready_queue_scheduler_top_defines.svh =====
// Assertion helpers used by the scheduler top level.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_TOP_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define PRQS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication with the consequent checked in the following cycle.
`define PRQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/prqs_pkg.sv =====
`default_nettype none
package prqs_pkg;

    localparam int SLOT_COUNT   = 32;
    localparam int TASK_SLOTS   = 8;
    localparam int SERVER_SLOTS = 4;
    localparam int QUEUES       = 3;
    localparam int SLOT_W       = 5;
    localparam int CNT_W        = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        Q_TASK   = 2'd0,
        Q_SERVER = 2'd1,
        Q_USER   = 2'd2
    } queue_t;

    typedef enum logic [1:0] {
        KIND_READY   = 2'd0,
        KIND_UNREADY = 2'd1,
        KIND_ROTATE  = 2'd2,
        KIND_REPICK  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [SLOT_W-1:0] current_slot;
        logic              idle;
        logic [SLOT_W-1:0] billed_slot;
        logic [SLOT_W-1:0] previous_billed_slot;
    } prqs_res_t;

    function automatic queue_t class_of(input logic [SLOT_W-1:0] s);
        queue_t q;
        if (int'(s) < TASK_SLOTS)
        begin
            q = Q_TASK;
        end
        else if (int'(s) < TASK_SLOTS + SERVER_SLOTS)
        begin
            q = Q_SERVER;
        end
        else
        begin
            q = Q_USER;
        end
        return q;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/priority_ready_queue_scheduler_top.sv =====
`default_nettype none
// Three-level ready-queue scheduler (task, server, user) over 32 process slots.
// One beat on s_* carries one event; each event returns exactly one beat on m_*
// with the selection after it. Make-unready of a non-head slot walks the links
// of its queue through the link memory, one entry per cycle, for at most 32
// steps. A new event is accepted once the previous one has been handed to the
// output register.
module priority_ready_queue_scheduler_top
    import prqs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [4:0] slot, [7:5] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [4:0] current_slot, [9:5] billed_slot,
                                        // [14:10] previous_billed_slot, [15] zero
    output logic      [0:0]  m_tuser    // [0] idle
);

    `include "priority_ready_queue_scheduler_top_defines.svh"

    logic              res_valid;
    logic              res_ready;
    prqs_res_t         res;
    logic              link_wr_en;
    logic [SLOT_W-1:0] link_wr_addr;
    logic [SLOT_W-1:0] link_wr_data;
    logic              link_rd_en;
    logic [SLOT_W-1:0] link_rd_addr;
    logic [SLOT_W-1:0] link_rd_data;

    logic              out_valid_reg;
    prqs_res_t         out_reg;

    logic              idle_beat_ok;
    logic              user_beat_ok;

    prqs_link_ram u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    prqs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_kind      (s_tuser),
        .in_slot      (s_tdata[SLOT_W-1:0]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .link_wr_en   (link_wr_en),
        .link_wr_addr (link_wr_addr),
        .link_wr_data (link_wr_data),
        .link_rd_en   (link_rd_en),
        .link_rd_addr (link_rd_addr),
        .link_rd_data (link_rd_data)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.previous_billed_slot, out_reg.billed_slot,
                       out_reg.current_slot};
    assign m_tuser  = out_reg.idle;

    assign idle_beat_ok = !(m_tvalid && m_tuser[0]) || (m_tdata[4:0] == '0);
    assign user_beat_ok = !(m_tvalid && !m_tuser[0] && class_of(m_tdata[4:0]) == Q_USER)
                          || (m_tdata[9:5] == m_tdata[4:0]);

    `PRQS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `PRQS_ASSERT_ALWAYS(a_idle_slot_zero, idle_beat_ok, "idle with nonzero slot")
    `PRQS_ASSERT_ALWAYS(a_user_billed, user_beat_ok, "user slot not billed")

endmodule
`default_nettype wire

// ===== rtl/prqs_link_ram.sv =====
`default_nettype none
module prqs_link_ram
    import prqs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [SLOT_W-1:0] wr_addr,
    input  wire logic [SLOT_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [SLOT_W-1:0] rd_addr,
    output logic      [SLOT_W-1:0] rd_data
);

    logic [SLOT_W-1:0] mem [SLOT_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/prqs_ctrl.sv =====
`default_nettype none
module prqs_ctrl
    import prqs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_kind,
    input  wire logic [SLOT_W-1:0] in_slot,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output prqs_res_t              res,
    output logic                   link_wr_en,
    output logic      [SLOT_W-1:0] link_wr_addr,
    output logic      [SLOT_W-1:0] link_wr_data,
    output logic                   link_rd_en,
    output logic      [SLOT_W-1:0] link_rd_addr,
    input  wire logic [SLOT_W-1:0] link_rd_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HEAD_LINK,
        ST_WALK,
        ST_FIX,
        ST_ROT_READ,
        ST_ROT_LINK,
        ST_PICK,
        ST_RESP
    } state_t;

    state_t            state_reg;
    kind_t             kind_reg;
    logic [SLOT_W-1:0] slot_reg;
    queue_t            q_reg;
    logic [SLOT_W-1:0] xp_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SLOT_W-1:0] head_reg [QUEUES];
    logic [SLOT_W-1:0] tail_reg [QUEUES];
    logic [QUEUES-1:0] ne_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic              idle_reg;
    logic [SLOT_W-1:0] billed_reg;
    logic [SLOT_W-1:0] prev_reg;

    logic              in_range;
    logic [SLOT_W-1:0] q_head;
    logic [SLOT_W-1:0] q_tail;
    logic [CNT_W-1:0]  cnt_inc;
    logic              walk_hit;
    logic              walk_end;
    logic              pick_found;
    queue_t            pick_q;
    logic [SLOT_W-1:0] pick_slot;

    assign in_range = CNT_W'(slot_reg) < CNT_W'(SLOT_COUNT);
    assign q_head   = head_reg[q_reg];
    assign q_tail   = tail_reg[q_reg];
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign walk_hit = link_rd_data == slot_reg;
    assign walk_end = (cnt_inc == CNT_W'(SLOT_COUNT)) || (link_rd_data == q_tail);

    // highest non-empty queue wins
    always_comb
    begin
        pick_found = |ne_reg;
        if (ne_reg[Q_TASK])
        begin
            pick_q = Q_TASK;
        end
        else if (ne_reg[Q_SERVER])
        begin
            pick_q = Q_SERVER;
        end
        else
        begin
            pick_q = Q_USER;
        end
        pick_slot = head_reg[pick_q];
    end

    always_comb
    begin
        link_wr_en   = 1'b0;
        link_wr_addr = q_tail;
        link_wr_data = slot_reg;
        link_rd_en   = 1'b0;
        link_rd_addr = slot_reg;
        case (state_reg)
            ST_EXEC:
            begin
                case (kind_reg)
                    KIND_READY:
                    begin
                        link_wr_en = in_range && ne_reg[q_reg];
                    end
                    KIND_UNREADY:
                    begin
                        if (in_range && ne_reg[q_reg])
                        begin
                            if (q_head == slot_reg)
                            begin
                                link_rd_en = q_tail != slot_reg;
                            end
                            else
                            begin
                                link_rd_en   = q_head != q_tail;
                                link_rd_addr = q_head;
                            end
                        end
                    end
                    KIND_ROTATE:
                    begin
                        link_wr_en   = ne_reg[Q_USER];
                        link_wr_addr = tail_reg[Q_USER];
                        link_wr_data = head_reg[Q_USER];
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_WALK:
            begin
                if (walk_hit)
                begin
                    link_rd_en = 1'b1;
                end
                else if (!walk_end)
                begin
                    link_rd_en   = 1'b1;
                    link_rd_addr = link_rd_data;
                end
            end
            ST_FIX:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = xp_reg;
                link_wr_data = link_rd_data;
            end
            ST_ROT_READ:
            begin
                // tail now holds the old head
                link_rd_en   = 1'b1;
                link_rd_addr = tail_reg[Q_USER];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ne_reg     <= '0;
            cur_reg    <= '0;
            idle_reg   <= 1'b1;
            billed_reg <= '0;
            prev_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_RESP;
                    cnt_reg   <= '0;
                    case (kind_reg)
                        KIND_READY:
                        begin
                            if (in_range)
                            begin
                                ne_reg[q_reg] <= 1'b1;
                            end
                        end
                        KIND_UNREADY:
                        begin
                            if (in_range && ne_reg[q_reg])
                            begin
                                if (q_head == slot_reg)
                                begin
                                    if (q_tail == slot_reg)
                                    begin
                                        ne_reg[q_reg] <= 1'b0;
                                        state_reg     <= ST_PICK;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_HEAD_LINK;
                                    end
                                end
                                else if (q_head != q_tail)
                                begin
                                    state_reg <= ST_WALK;
                                end
                            end
                        end
                        KIND_ROTATE:
                        begin
                            if (ne_reg[Q_USER])
                            begin
                                state_reg <= ST_ROT_READ;
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_PICK;
                        end
                    endcase
                end
                ST_HEAD_LINK:
                begin
                    state_reg <= ST_PICK;
                end
                ST_WALK:
                begin
                    cnt_reg <= cnt_inc;
                    if (walk_hit)
                    begin
                        state_reg <= ST_FIX;
                    end
                    else if (walk_end)
                    begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_FIX:
                begin
                    state_reg <= ST_RESP;
                end
                ST_ROT_READ:
                begin
                    state_reg <= ST_ROT_LINK;
                end
                ST_ROT_LINK:
                begin
                    state_reg <= ST_PICK;
                end
                ST_PICK:
                begin
                    state_reg <= ST_RESP;
                    if (pick_found)
                    begin
                        if (!idle_reg && class_of(cur_reg) == Q_USER)
                        begin
                            prev_reg <= billed_reg;
                        end
                        cur_reg  <= pick_slot;
                        idle_reg <= 1'b0;
                        if (class_of(pick_slot) == Q_USER)
                        begin
                            billed_reg <= pick_slot;
                        end
                    end
                    else
                    begin
                        cur_reg  <= '0;
                        idle_reg <= 1'b1;
                    end
                end
                ST_RESP:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // queue ends and walk pointers carry no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_reg <= kind_t'(in_kind);
                    slot_reg <= in_slot;
                    q_reg    <= class_of(in_slot);
                end
            end
            ST_EXEC:
            begin
                xp_reg <= q_head;
                case (kind_reg)
                    KIND_READY:
                    begin
                        if (in_range)
                        begin
                            if (!ne_reg[q_reg])
                            begin
                                head_reg[q_reg] <= slot_reg;
                            end
                            tail_reg[q_reg] <= slot_reg;
                        end
                    end
                    KIND_ROTATE:
                    begin
                        q_reg <= Q_USER;
                        if (ne_reg[Q_USER])
                        begin
                            tail_reg[Q_USER] <= head_reg[Q_USER];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_HEAD_LINK:
            begin
                head_reg[q_reg] <= link_rd_data;
            end
            ST_WALK:
            begin
                if (!walk_hit)
                begin
                    xp_reg <= link_rd_data;
                end
            end
            ST_FIX:
            begin
                if (q_tail == slot_reg)
                begin
                    tail_reg[q_reg] <= xp_reg;
                end
            end
            ST_ROT_LINK:
            begin
                head_reg[Q_USER] <= link_rd_data;
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready                 = state_reg == ST_IDLE;
    assign res_valid                = state_reg == ST_RESP;
    assign res.current_slot         = cur_reg;
    assign res.idle                 = idle_reg;
    assign res.billed_slot          = billed_reg;
    assign res.previous_billed_slot = prev_reg;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import prqs_pkg::*;

    // Scheduler state, plus a flag per link entry telling whether it was ever written.
    typedef struct packed {
        logic [SLOT_COUNT-1:0][SLOT_W-1:0] link;
        logic [SLOT_COUNT-1:0]             link_set;
        logic [QUEUES-1:0][SLOT_W-1:0]     head;
        logic [QUEUES-1:0][SLOT_W-1:0]     tail;
        logic [QUEUES-1:0]                 busy;
        logic [SLOT_W-1:0]                 cur;
        logic                              idle;
        logic [SLOT_W-1:0]                 billed;
        logic [SLOT_W-1:0]                 prev_billed;
    } ready_state_t;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
    } sched_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [4:0] slot, [7:5] zero
    logic [1:0]  s_tuser = 2'b00;   // [1:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [4:0] current_slot, [9:5] billed_slot,
                                    // [14:10] previous_billed_slot, [15] zero
    logic [0:0]  m_tuser;           // [0] idle

    sched_event_t pending_events[$];
    prqs_res_t    expected_sel[$];
    ready_state_t gen_state;
    ready_state_t sched_state;

    int  send_gap_pct = 0;
    int  recv_stall_pct = 0;
    int  errors = 0;
    int  results_checked = 0;
    int  kind_count[4];
    bit  in_beat = 1'b0;
    bit  link_miss;
    prqs_res_t want;

    priority_ready_queue_scheduler_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic ready_state_t reset_state();
        ready_state_t st;
        st = '0;
        st.idle = 1'b1;
        return st;
    endfunction

    function automatic queue_t slot_class(input logic [SLOT_W-1:0] s);
        if (int'(s) < TASK_SLOTS)
        begin
            return Q_TASK;
        end
        if (int'(s) < TASK_SLOTS + SERVER_SLOTS)
        begin
            return Q_SERVER;
        end
        return Q_USER;
    endfunction

    function automatic logic [SLOT_W-1:0] link_after(input ready_state_t st,
                                                     input logic [SLOT_W-1:0] s,
                                                     inout bit bad);
        if (!st.link_set[s])
        begin
            bad = 1'b1;
        end
        return st.link[s];
    endfunction

    // Head of the highest non-empty queue, or idle.
    function automatic void select_next(inout ready_state_t st);
        int q;
        int sel;
        bit found;
        sel = 0;
        found = 1'b0;
        for (q = QUEUES - 1; q >= 0; q--)
        begin
            if (st.busy[q])
            begin
                sel = q;
                found = 1'b1;
            end
        end
        if (found)
        begin
            if (!st.idle && slot_class(st.cur) == Q_USER)
            begin
                st.prev_billed = st.billed;
            end
            st.cur = st.head[sel];
            st.idle = 1'b0;
            if (slot_class(st.cur) == Q_USER)
            begin
                st.billed = st.cur;
            end
        end
        else
        begin
            st.cur = '0;
            st.idle = 1'b1;
        end
    endfunction

    // bad is set when the event would read a link entry never written.
    function automatic void apply_event(inout ready_state_t st, input kind_t k,
                                        input logic [SLOT_W-1:0] s, output bit bad);
        queue_t            q;
        logic [SLOT_W-1:0] xp;
        logic [SLOT_W-1:0] nx;
        int                n;
        bit                done;
        bad = 1'b0;
        q = slot_class(s);
        case (k)
            KIND_READY:
            begin
                if (!st.busy[q])
                begin
                    st.head[q] = s;
                    st.busy[q] = 1'b1;
                end
                else
                begin
                    st.link[st.tail[q]] = s;
                    st.link_set[st.tail[q]] = 1'b1;
                end
                st.tail[q] = s;
            end
            KIND_UNREADY:
            begin
                if (st.busy[q] && st.head[q] == s)
                begin
                    if (st.tail[q] == s)
                    begin
                        st.busy[q] = 1'b0;
                    end
                    else
                    begin
                        st.head[q] = link_after(st, s, bad);
                    end
                    select_next(st);
                end
                else if (st.busy[q])
                begin
                    // walk bounded to SLOT_COUNT steps, duplicates may form loops
                    xp = st.head[q];
                    done = 1'b0;
                    for (n = 0; n < SLOT_COUNT; n++)
                    begin
                        if (!done && xp == st.tail[q])
                        begin
                            done = 1'b1;
                        end
                        else if (!done)
                        begin
                            nx = link_after(st, xp, bad);
                            if (nx == s)
                            begin
                                st.link[xp] = link_after(st, s, bad);
                                st.link_set[xp] = 1'b1;
                                if (st.tail[q] == s)
                                begin
                                    st.tail[q] = xp;
                                end
                                done = 1'b1;
                            end
                            else
                            begin
                                xp = nx;
                            end
                        end
                    end
                end
            end
            KIND_ROTATE:
            begin
                if (st.busy[Q_USER])
                begin
                    xp = st.head[Q_USER];
                    st.link[st.tail[Q_USER]] = xp;
                    st.link_set[st.tail[Q_USER]] = 1'b1;
                    st.tail[Q_USER] = xp;
                    st.head[Q_USER] = link_after(st, xp, bad);
                    select_next(st);
                end
            end
            default:
            begin
                select_next(st);
            end
        endcase
    endfunction

    function automatic logic [SLOT_COUNT-1:0] queued_slots(input ready_state_t st);
        logic [SLOT_COUNT-1:0] m;
        logic [SLOT_W-1:0]     xp;
        int                    q;
        int                    n;
        bit                    done;
        m = '0;
        for (q = 0; q < QUEUES; q++)
        begin
            xp = st.head[q];
            done = !st.busy[q];
            for (n = 0; n < SLOT_COUNT; n++)
            begin
                if (!done)
                begin
                    m[xp] = 1'b1;
                    if (xp == st.tail[q])
                    begin
                        done = 1'b1;
                    end
                    xp = st.link[xp];
                end
            end
        end
        return m;
    endfunction

    // Queue the event only if it keeps clear of unwritten link entries.
    function automatic bit offer_event(input kind_t k, input logic [SLOT_W-1:0] s);
        ready_state_t trial;
        bit           bad;
        trial = gen_state;
        apply_event(trial, k, s, bad);
        if (!bad)
        begin
            gen_state = trial;
            pending_events.push_back('{kind: k, slot: s});
        end
        return !bad;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot(input logic [SLOT_COUNT-1:0] m,
                                                    input bit want_member);
        logic [SLOT_W-1:0] s;
        int                tries;
        s = '0;
        for (tries = 0; tries < 8; tries++)
        begin
            case ($urandom_range(2))
                0: s = SLOT_W'($urandom_range(TASK_SLOTS - 1, 0));
                1: s = SLOT_W'($urandom_range(TASK_SLOTS + SERVER_SLOTS - 1, TASK_SLOTS));
                default: s = SLOT_W'($urandom_range(SLOT_COUNT - 1,
                                                    TASK_SLOTS + SERVER_SLOTS));
            endcase
            if (m[s] == want_member)
            begin
                return s;
            end
        end
        return s;
    endfunction

    function automatic void add_random_events(input int count);
        logic [SLOT_COUNT-1:0] m;
        int                    i;
        int                    r;
        int                    tries;
        bit                    ok;
        for (i = 0; i < count; i++)
        begin
            ok = 1'b0;
            for (tries = 0; tries < 16 && !ok; tries++)
            begin
                m = queued_slots(gen_state);
                r = $urandom_range(99);
                if (r < 38)
                begin
                    // mostly fresh slots, now and then one already queued
                    ok = offer_event(KIND_READY, pick_slot(m, $urandom_range(99) < 4));
                end
                else if (r < 76)
                begin
                    ok = offer_event(KIND_UNREADY, pick_slot(m, $urandom_range(99) < 85));
                end
                else if (r < 88)
                begin
                    ok = offer_event(KIND_ROTATE, SLOT_W'($urandom));
                end
                else
                begin
                    ok = offer_event(KIND_REPICK, SLOT_W'($urandom));
                end
            end
            if (!ok)
            begin
                ok = offer_event(KIND_REPICK, '0);
            end
        end
    endfunction

    // Driver: new beat only once the previous one was taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_beat)
        begin
            if (pending_events.size() > 0 && $urandom_range(99) >= send_gap_pct)
            begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_events[0].kind;
                s_tdata <= {3'b000, pending_events[0].slot};
                void'(pending_events.pop_front());
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        in_beat = 1'b0;
        m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on accepted events, check accepted results.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            in_beat = 1'b1;
            kind_count[s_tuser]++;
            apply_event(sched_state, kind_t'(s_tuser), s_tdata[SLOT_W-1:0], link_miss);
            want.current_slot = sched_state.cur;
            want.idle = sched_state.idle;
            want.billed_slot = sched_state.billed;
            want.previous_billed_slot = sched_state.prev_billed;
            expected_sel.push_back(want);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_sel.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat tdata=%h tuser=%b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = expected_sel.pop_front();
                results_checked++;
                if (m_tdata[4:0] != want.current_slot || m_tuser[0] != want.idle ||
                    m_tdata[9:5] != want.billed_slot ||
                    m_tdata[14:10] != want.previous_billed_slot)
                begin
                    errors++;
                    if (errors <= 100)
                    begin
                        $display("%0t: result %0d expected cur=%0d idle=%0b bill=%0d prev=%0d",
                                 $time, results_checked, want.current_slot, want.idle,
                                 want.billed_slot, want.previous_billed_slot);
                        $display("%0t: result %0d actual   cur=%0d idle=%0b bill=%0d prev=%0d",
                                 $time, results_checked, m_tdata[4:0], m_tuser[0],
                                 m_tdata[9:5], m_tdata[14:10]);
                    end
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        bit ok;
        gen_state = reset_state();
        sched_state = reset_state();

        // empty queues first, then each queue built up and torn down
        ok = offer_event(KIND_REPICK, 5'd0);
        ok = offer_event(KIND_ROTATE, 5'd0);
        ok = offer_event(KIND_UNREADY, 5'd31);
        ok = offer_event(KIND_READY, 5'd31);
        ok = offer_event(KIND_READY, 5'd12);
        ok = offer_event(KIND_REPICK, 5'd0);
        ok = offer_event(KIND_READY, 5'd0);
        ok = offer_event(KIND_READY, 5'd7);
        ok = offer_event(KIND_REPICK, 5'd31);
        ok = offer_event(KIND_READY, 5'd8);
        ok = offer_event(KIND_READY, 5'd11);
        ok = offer_event(KIND_UNREADY, 5'd3);   // absent from a non-empty queue
        ok = offer_event(KIND_UNREADY, 5'd0);   // head with successor
        ok = offer_event(KIND_UNREADY, 5'd7);   // sole entry, task queue empties
        ok = offer_event(KIND_ROTATE, 5'd0);
        ok = offer_event(KIND_READY, 5'd20);
        ok = offer_event(KIND_UNREADY, 5'd31);  // middle of user queue
        ok = offer_event(KIND_ROTATE, 5'd31);
        ok = offer_event(KIND_UNREADY, 5'd12);  // tail
        ok = offer_event(KIND_UNREADY, 5'd8);
        ok = offer_event(KIND_UNREADY, 5'd11);
        ok = offer_event(KIND_READY, 5'd20);    // already queued
        ok = offer_event(KIND_UNREADY, 5'd20);
        ok = offer_event(KIND_REPICK, 5'd0);

        send_gap_pct = 14;
        recv_stall_pct = 69;
        add_random_events(509);
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        while (pending_events.size() != 0 || expected_sel.size() != 0)
        begin
            @(posedge clk);
        end

        send_gap_pct = 69;
        recv_stall_pct = 14;
        add_random_events(508);
        while (pending_events.size() != 0 || expected_sel.size() != 0)
        begin
            @(posedge clk);
        end

        send_gap_pct = 0;
        recv_stall_pct = 0;
        add_random_events(508);
        while (pending_events.size() != 0 || expected_sel.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);

        $display("events: %0d ready, %0d unready, %0d rotate, %0d repick",
                 kind_count[KIND_READY], kind_count[KIND_UNREADY],
                 kind_count[KIND_ROTATE], kind_count[KIND_REPICK]);
        $display("selections checked: %0d, mismatches: %0d", results_checked, errors);
        if (errors == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
